// File: sv/lcpm_pkg.sv
// shared types and constants for the led cube plane multiplexer
package lcpm_pkg;

	// operation codes
	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_VOXEL = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	// frame buffer geometry
	localparam int PLANES      = 3;
	localparam int B_BITS      = 6;
	localparam int C_BITS      = 3;
	localparam logic [2:0] LAST_PHASE = 3'd5;
	localparam logic [3:0] GROUP_C_BASE = 4'd6;
	localparam logic [3:0] CELL_LIMIT   = 4'd9;

	// one command item
	typedef struct packed {
		logic [1:0] operation;
		logic [1:0] plane_index;
		logic [1:0] row_index;
		logic [1:0] column_index;
		logic       voxel_on;
	} cmd_t;

	// one port drive result
	typedef struct packed {
		logic [5:0] port_b_drive;
		logic [5:0] port_c_drive;
	} drive_t;

endpackage

// File: sv/lcpm_scan_core.sv
// frame buffer, scan phase counter and port drive decode
module lcpm_scan_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  lcpm_pkg::cmd_t    cmd,
	output lcpm_pkg::drive_t  result
);

	logic [lcpm_pkg::B_BITS-1:0] group_b_q [lcpm_pkg::PLANES];
	logic [lcpm_pkg::C_BITS-1:0] group_c_q [lcpm_pkg::PLANES];
	logic [2:0]                  phase_q;

	logic [2:0] phase_next;
	logic [1:0] plane;
	logic [2:0] select_n;
	logic [3:0] cell_raw;
	logic [3:0] cell_num;
	logic [3:0] cell_c;
	logic [lcpm_pkg::B_BITS-1:0] mask_b;
	logic [lcpm_pkg::C_BITS-1:0] mask_c;

	// next phase and scanned plane
	always_comb begin
		phase_next = (phase_q >= lcpm_pkg::LAST_PHASE) ? 3'd0 : phase_q + 3'd1;
		plane      = phase_next[2:1];
		select_n   = ~(3'd1 << plane);
		result.port_b_drive = 6'd0;
		result.port_c_drive = {3'd0, select_n};
		if (plane < 2'd3) begin
			if (!phase_next[0]) begin
				result.port_b_drive = group_b_q[plane];
			end else begin
				result.port_c_drive = {group_c_q[plane], select_n};
			end
		end
	end

	// voxel cell number x + 3y with cells 0 and 2 swapped
	always_comb begin
		cell_raw = {2'd0, cmd.column_index} + {1'b0, cmd.row_index, 1'b0}
			+ {2'd0, cmd.row_index};
		case (cell_raw)
			4'd0:    cell_num = 4'd2;
			4'd2:    cell_num = 4'd0;
			default: cell_num = cell_raw;
		endcase
		cell_c = cell_num - lcpm_pkg::GROUP_C_BASE;
		mask_b = '0;
		mask_c = '0;
		if (cell_num < lcpm_pkg::GROUP_C_BASE) begin
			mask_b = 6'd1 << cell_num[2:0];
		end else if (cell_num < lcpm_pkg::CELL_LIMIT) begin
			mask_c = 3'd1 << cell_c[1:0];
		end
	end

	// buffer and phase update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 3'd0;
			for (int i = 0; i < lcpm_pkg::PLANES; i++) begin
				group_b_q[i] <= '0;
				group_c_q[i] <= '0;
			end
		end else if (step) begin
			case (cmd.operation)
				lcpm_pkg::OP_TICK: begin
					phase_q <= phase_next;
				end
				lcpm_pkg::OP_VOXEL: begin
					for (int i = 0; i < lcpm_pkg::PLANES; i++) begin
						if (cmd.plane_index == 2'(i)) begin
							if (cmd.voxel_on) begin
								group_b_q[i] <= group_b_q[i] | mask_b;
								group_c_q[i] <= group_c_q[i] | mask_c;
							end else begin
								group_b_q[i] <= group_b_q[i] & ~mask_b;
								group_c_q[i] <= group_c_q[i] & ~mask_c;
							end
						end
					end
				end
				lcpm_pkg::OP_CLEAR: begin
					for (int i = 0; i < lcpm_pkg::PLANES; i++) begin
						group_b_q[i] <= '0;
						group_c_q[i] <= '0;
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// File: sv/led_cube_plane_multiplexer_unit.sv
// led cube plane multiplexer: command input register, scan core, drive output register
// a refresh tick's drive result is registered once it leaves the input register
// one command is accepted every cycle unless stalled; voxel and clear yield no result
// a tick in the input register waits while a finished result is stalled, stalling input
// asynchronous active-low reset clears the frame buffer, the scan phase and both
// valid flags; payload registers are not reset
module led_cube_plane_multiplexer_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_stall,
	input  lcpm_pkg::cmd_t    cmd,
	output logic              drive_valid,
	input  logic              drive_stall,
	output lcpm_pkg::drive_t  drive
);

	logic              valid_s1;
	lcpm_pkg::cmd_t    cmd_s1;
	logic              is_tick_s1;
	logic              advance_s1;
	logic              step;
	lcpm_pkg::drive_t  result;
	logic              drive_valid_q;
	lcpm_pkg::drive_t  drive_q;

	// a tick may leave stage 1 only when the output register is free
	assign is_tick_s1 = (cmd_s1.operation == lcpm_pkg::OP_TICK);
	assign advance_s1 = !is_tick_s1 || !drive_valid_q || !drive_stall;
	assign step       = valid_s1 && advance_s1;
	assign cmd_stall  = valid_s1 && !advance_s1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!cmd_stall) begin
			valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!cmd_stall && cmd_valid) begin
			cmd_s1 <= cmd;
		end
	end

	lcpm_scan_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.cmd    (cmd_s1),
		.result (result)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drive_valid_q <= 1'b0;
		end else if (step && is_tick_s1) begin
			drive_valid_q <= 1'b1;
		end else if (!drive_stall) begin
			drive_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && is_tick_s1) begin
			drive_q <= result;
		end
	end

	assign drive_valid = drive_valid_q;
	assign drive       = drive_q;

endmodule

// File: tb/sv/tb_led_cube_plane_multiplexer_unit.sv
// self-checking testbench for the led cube plane multiplexer unit
`timescale 1ns / 100ps

module tb_led_cube_plane_multiplexer_unit;

	// operation code the block must ignore
	localparam logic [1:0] OP_UNUSED = 2'd3;

	localparam int RANDOM_ITEMS = 1600;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 8;

	// one queued command and whether the sender drains the block before it
	typedef struct {
		lcpm_pkg::cmd_t word;
		bit             drain;
	} cmd_slot_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cmd_valid = 1'b0;
	logic             cmd_stall;
	lcpm_pkg::cmd_t   cmd = '0;
	logic             drive_valid;
	logic             drive_stall = 1'b0;
	lcpm_pkg::drive_t drive;

	cmd_slot_t        cmd_queue[$];
	lcpm_pkg::drive_t pending_drives[$];
	int               errors = 0;
	int               cycle_count = 0;
	bit               cmd_taken = 1'b0;

	// predicted frame buffer and scan phase
	logic [lcpm_pkg::B_BITS-1:0] frame_b [lcpm_pkg::PLANES] = '{default: '0};
	logic [lcpm_pkg::C_BITS-1:0] frame_c [lcpm_pkg::PLANES] = '{default: '0};
	logic [2:0]                  phase_now = 3'd0;

	// sender burst and receiver stall pattern state
	int burst_left = 0;
	int gap_left = 0;
	int stall_mode = 0;
	int stall_mode_left = 0;
	bit stall_toggle = 1'b0;

	led_cube_plane_multiplexer_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (cmd_valid),
		.cmd_stall   (cmd_stall),
		.cmd         (cmd),
		.drive_valid (drive_valid),
		.drive_stall (drive_stall),
		.drive       (drive)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// apply one command to the predicted cube, returns 1 when it yields a drive word
	function automatic bit cube_step(input lcpm_pkg::cmd_t c, output lcpm_pkg::drive_t d);
		logic [3:0] cell_num;
		logic [1:0] plane;
		logic [2:0] sel;
		d = '0;
		case (c.operation)
			lcpm_pkg::OP_TICK: begin
				phase_now = (phase_now >= lcpm_pkg::LAST_PHASE) ? 3'd0 : phase_now + 3'd1;
				plane = phase_now[2:1];
				sel = ~(3'b001 << plane);
				if (!phase_now[0]) begin
					d.port_b_drive = frame_b[plane];
					d.port_c_drive = {3'b000, sel};
				end else begin
					d.port_b_drive = '0;
					d.port_c_drive = {frame_c[plane], sel};
				end
				return 1'b1;
			end
			lcpm_pkg::OP_VOXEL: begin
				if (c.plane_index < lcpm_pkg::PLANES) begin
					cell_num = {2'b00, c.column_index} + 4'd3 * {2'b00, c.row_index};
					// cells 0 and 2 trade places in the wiring
					if (cell_num == 4'd0)
						cell_num = 4'd2;
					else if (cell_num == 4'd2)
						cell_num = 4'd0;
					if (cell_num < lcpm_pkg::GROUP_C_BASE)
						frame_b[c.plane_index][cell_num] = c.voxel_on;
					else if (cell_num < lcpm_pkg::CELL_LIMIT)
						frame_c[c.plane_index][cell_num - lcpm_pkg::GROUP_C_BASE] =
							c.voxel_on;
				end
			end
			lcpm_pkg::OP_CLEAR: begin
				for (int i = 0; i < lcpm_pkg::PLANES; i++) begin
					frame_b[i] = '0;
					frame_c[i] = '0;
				end
			end
			default: ;
		endcase
		return 1'b0;
	endfunction

	task automatic push_cmd(input logic [1:0] op, input logic [1:0] z, input logic [1:0] y,
			input logic [1:0] x, input logic on, input bit drain);
		cmd_slot_t s;
		s.word.operation = op;
		s.word.plane_index = z;
		s.word.row_index = y;
		s.word.column_index = x;
		s.word.voxel_on = on;
		s.drain = drain;
		cmd_queue.push_back(s);
	endtask

	// monitor: check drive transfers, then predict from the command transfer
	always @(posedge clk) begin
		lcpm_pkg::drive_t want;
		lcpm_pkg::drive_t got;
		got = drive;
		if (arst_n && drive_valid && !drive_stall) begin
			if (pending_drives.size() == 0) begin
				$error("drive transfer with nothing expected: b %0h c %0h",
					got.port_b_drive, got.port_c_drive);
				errors++;
			end else begin
				want = pending_drives.pop_front();
				if (got.port_b_drive !== want.port_b_drive) begin
					$error("port_b_drive expected %0h actual %0h",
						want.port_b_drive, got.port_b_drive);
					errors++;
				end
				if (got.port_c_drive !== want.port_c_drive) begin
					$error("port_c_drive expected %0h actual %0h",
						want.port_c_drive, got.port_c_drive);
					errors++;
				end
			end
		end
		cmd_taken = arst_n && cmd_valid && !cmd_stall;
		if (cmd_taken && cube_step(cmd, want))
			pending_drives.push_back(want);
	end

	// driver: bursts of commands with random gaps, holds a stalled command
	always @(negedge clk) begin
		cmd_slot_t s;
		logic v_next;
		lcpm_pkg::cmd_t c_next;
		v_next = cmd_valid;
		c_next = cmd;
		if (!arst_n) begin
			v_next = 1'b0;
		end else if (!(cmd_valid && !cmd_taken)) begin
			v_next = 1'b0;
			if (gap_left > 0) begin
				gap_left--;
			end else if (cmd_queue.size() != 0 &&
					!(cmd_queue[0].drain && pending_drives.size() != 0)) begin
				s = cmd_queue.pop_front();
				v_next = 1'b1;
				c_next = s.word;
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 24);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left--;
				end
			end
		end
		cmd_valid <= v_next;
		cmd <= c_next;
	end

	// receiver: stall pattern switching between free, random, alternating and heavy
	always @(negedge clk) begin
		logic s;
		if (stall_mode_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_mode_left = $urandom_range(20, 120);
		end else begin
			stall_mode_left--;
		end
		stall_toggle = !stall_toggle;
		case (stall_mode)
			0: s = 1'b0;
			1: s = 1'($urandom_range(0, 1));
			2: s = stall_toggle;
			default: s = ($urandom_range(0, 9) < 8);
		endcase
		drive_stall <= s;
	end

	// reset once
	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
	end

	// run limit
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb: failure");
		$finish;
	end

	// stimulus and end of run
	initial begin
		int roll;
		logic [1:0] op;
		logic [1:0] z;
		logic [1:0] y;
		logic [1:0] x;

		// directed: phase walk, cell swap, group c cells, ignored writes, wrap, clear
		push_cmd(lcpm_pkg::OP_TICK, 2'd3, 2'd3, 2'd3, 1'b1, 1'b0);
		push_cmd(lcpm_pkg::OP_TICK, 2'd0, 2'd0, 2'd0, 1'b0, 1'b0);
		push_cmd(lcpm_pkg::OP_VOXEL, 2'd2, 2'd0, 2'd0, 1'b1, 1'b0);
		push_cmd(lcpm_pkg::OP_VOXEL, 2'd2, 2'd0, 2'd2, 1'b1, 1'b0);
		push_cmd(lcpm_pkg::OP_VOXEL, 2'd2, 2'd2, 2'd2, 1'b1, 1'b0);
		push_cmd(lcpm_pkg::OP_VOXEL, 2'd2, 2'd1, 2'd3, 1'b1, 1'b0);
		push_cmd(lcpm_pkg::OP_VOXEL, 2'd2, 2'd3, 2'd0, 1'b1, 1'b0);
		push_cmd(lcpm_pkg::OP_VOXEL, 2'd3, 2'd1, 2'd1, 1'b1, 1'b0);
		push_cmd(lcpm_pkg::OP_VOXEL, 2'd0, 2'd3, 2'd3, 1'b1, 1'b0);
		push_cmd(lcpm_pkg::OP_VOXEL, 2'd0, 2'd0, 2'd3, 1'b1, 1'b0);
		push_cmd(OP_UNUSED, 2'd3, 2'd3, 2'd3, 1'b1, 1'b0);
		repeat (4) push_cmd(lcpm_pkg::OP_TICK, 2'd0, 2'd0, 2'd0, 1'b0, 1'b0);
		push_cmd(lcpm_pkg::OP_VOXEL, 2'd2, 2'd0, 2'd0, 1'b0, 1'b0);
		push_cmd(lcpm_pkg::OP_VOXEL, 2'd1, 2'd1, 2'd1, 1'b1, 1'b0);
		repeat (4) push_cmd(lcpm_pkg::OP_TICK, 2'd0, 2'd0, 2'd0, 1'b0, 1'b0);
		// sender waits for every drive word before the clear
		push_cmd(lcpm_pkg::OP_CLEAR, 2'd3, 2'd3, 2'd3, 1'b1, 1'b1);
		repeat (2) push_cmd(lcpm_pkg::OP_TICK, 2'd0, 2'd0, 2'd0, 1'b0, 1'b0);

		// random mix, mostly ticks and in-range voxel writes
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			roll = $urandom_range(0, 99);
			if (roll < 45)
				op = lcpm_pkg::OP_TICK;
			else if (roll < 94)
				op = lcpm_pkg::OP_VOXEL;
			else if (roll < 97)
				op = lcpm_pkg::OP_CLEAR;
			else
				op = OP_UNUSED;
			if ($urandom_range(0, 9) == 0) begin
				z = 2'($urandom_range(0, 3));
				y = 2'($urandom_range(0, 3));
				x = 2'($urandom_range(0, 3));
			end else begin
				z = 2'($urandom_range(0, 2));
				y = 2'($urandom_range(0, 2));
				x = 2'($urandom_range(0, 2));
			end
			push_cmd(op, z, y, x, ($urandom_range(0, 9) < 6),
				($urandom_range(0, 199) == 0));
		end

		// wait for all transfers to finish, then let the pipeline settle
		@(posedge arst_n);
		while (cmd_queue.size() != 0 || cmd_valid || pending_drives.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (errors == 0 && pending_drives.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// File: led_cube_plane_multiplexer_unit.f
sv/lcpm_pkg.sv
sv/lcpm_scan_core.sv
sv/led_cube_plane_multiplexer_unit.sv
tb/sv/tb_led_cube_plane_multiplexer_unit.sv
